[src/acs_pkg.sv]
// Package for the assembly comment stripper: scan modes, pair actions,
// character codes and the scanner state record. No dependencies.
package acs_pkg;

    localparam int unsigned ByteW = 8;

    typedef logic [ByteW-1:0] byte_t;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_STOPPED = 3'd4
    } scan_mode_t;

    typedef enum logic [1:0] {
        PAIR_NONE  = 2'd0,
        PAIR_PASS  = 2'd1,
        PAIR_OPEN  = 2'd2,
        PAIR_CLOSE = 2'd3
    } pair_action_t;

    localparam byte_t CH_NUL    = 8'h00;
    localparam byte_t CH_AT     = 8'h40;
    localparam byte_t CH_SLASH  = 8'h2F;
    localparam byte_t CH_STAR   = 8'h2A;
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_NL     = 8'h0A;
    localparam byte_t CH_SPACE  = 8'h20;
    localparam byte_t CH_DQUOTE = 8'h22;
    localparam byte_t CH_SQUOTE = 8'h27;

    typedef struct packed {
        scan_mode_t   scan_mode;
        byte_t        quote_char;
        pair_action_t pair_action;
        logic         prev_backslash;
    } scan_state_t;

endpackage

[src/acs_step.sv]
// Combinational scanner step: from the current state and one byte with its
// lookahead, forms the output byte and the next scanner state. Uses acs_pkg.
module acs_step
    import acs_pkg::*;
(
    input  scan_state_t state,
    input  byte_t       cur_byte,
    input  byte_t       next_byte,
    output scan_state_t state_next,
    output byte_t       out_byte
);

    // Output byte.
    always_comb
    begin
        out_byte = cur_byte;
        if (state.scan_mode == MODE_STOPPED)
        begin
            out_byte = cur_byte;
        end
        else if (cur_byte == CH_NUL)
        begin
            out_byte = CH_NUL;
        end
        else if (state.pair_action != PAIR_NONE)
        begin
            out_byte = (state.pair_action == PAIR_PASS) ? cur_byte : CH_SPACE;
        end
        else
        begin
            case (state.scan_mode)
                MODE_STRING:
                begin
                    out_byte = cur_byte;
                end
                MODE_LINE:
                begin
                    out_byte = (cur_byte == CH_NL) ? cur_byte : CH_SPACE;
                end
                MODE_BLOCK:
                begin
                    out_byte = (cur_byte == CH_NL && next_byte != CH_SLASH) ||
                               (cur_byte == CH_NL) ? cur_byte : CH_SPACE;
                end
                default:
                begin
                    if (cur_byte == CH_AT && !state.prev_backslash)
                    begin
                        out_byte = CH_SPACE;
                    end
                    else if (cur_byte == CH_SLASH && next_byte == CH_STAR)
                    begin
                        out_byte = CH_SPACE;
                    end
                    else
                    begin
                        out_byte = cur_byte;
                    end
                end
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state;
        if (state.scan_mode == MODE_STOPPED)
        begin
            state_next.scan_mode = MODE_STOPPED;
        end
        else if (cur_byte == CH_NUL)
        begin
            state_next.scan_mode   = MODE_STOPPED;
            state_next.pair_action = PAIR_NONE;
        end
        else if (state.pair_action != PAIR_NONE)
        begin
            // This byte is the second half of a claimed pair.
            state_next.pair_action = PAIR_NONE;
        end
        else
        begin
            case (state.scan_mode)
                MODE_STRING:
                begin
                    if (cur_byte == CH_BSLASH && next_byte == state.quote_char)
                    begin
                        state_next.pair_action = PAIR_PASS;
                    end
                    else if (cur_byte == state.quote_char)
                    begin
                        state_next.scan_mode  = MODE_NORMAL;
                        state_next.quote_char = CH_NUL;
                    end
                end
                MODE_LINE:
                begin
                    if (cur_byte == CH_NL)
                    begin
                        state_next.scan_mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (cur_byte == CH_STAR && next_byte == CH_SLASH)
                    begin
                        state_next.scan_mode   = MODE_NORMAL;
                        state_next.pair_action = PAIR_CLOSE;
                    end
                end
                default:
                begin
                    state_next.scan_mode = MODE_NORMAL;
                    if (cur_byte == CH_AT && !state.prev_backslash)
                    begin
                        state_next.scan_mode = MODE_LINE;
                    end
                    else if (cur_byte == CH_SLASH && next_byte == CH_STAR)
                    begin
                        state_next.scan_mode   = MODE_BLOCK;
                        state_next.pair_action = PAIR_OPEN;
                    end
                    else if (cur_byte == CH_DQUOTE || cur_byte == CH_SQUOTE)
                    begin
                        state_next.scan_mode  = MODE_STRING;
                        state_next.quote_char = cur_byte;
                    end
                end
            endcase
        end
        state_next.prev_backslash = (out_byte == CH_BSLASH);
    end

endmodule

[src/asm_comment_stripper.sv]
// Top level of the assembly comment stripper: input register, scanner state,
// result register. Depends on acs_pkg and acs_step.
//
// Usage:
//   The slave channel takes one source byte per transaction together with the
//   byte after it as lookahead (0 when there is none). The master channel
//   returns one byte per transaction: the same byte, or a space where it lies
//   inside an '@' line comment or a block comment, where newlines still pass.
//   Strings pass unchanged, and a zero byte stops all blanking until the next reset.
//   An accepted input transaction waits in the input register; the scanner
//   step then writes the result register and the scanner state, and the
//   result register offers the byte on the master channel.
//   Throughput is one byte per cycle while the receiver takes each result;
//   the scanner step is a single short compare-and-select level, and its
//   state feeds back within that cycle. When the receiver stalls, the result
//   register holds its byte and the input register still takes one more
//   transaction, after which s_axis_tready drops until the result is taken.
//   Reset (rst_n low, asynchronous) empties both registers and returns the
//   scanner to normal text with no open string or pending pair.
module asm_comment_stripper
    import acs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [7:0] cur_byte, [15:8] next_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // [7:0] out_byte
);

    logic        in_valid_reg;
    logic        in_valid_next;
    byte_t       cur_byte_reg;
    byte_t       next_byte_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    byte_t       out_byte_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    byte_t       step_byte;
    logic        out_free;
    logic        advance;
    logic        take_in;

    acs_step u_step (
        .state      (state_reg),
        .cur_byte   (cur_byte_reg),
        .next_byte  (next_byte_reg),
        .state_next (state_next),
        .out_byte   (step_byte)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign take_in       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{scan_mode:      MODE_NORMAL,
                               quote_char:     CH_NUL,
                               pair_action:    PAIR_NONE,
                               prev_backslash: 1'b0};
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cur_byte_reg  <= s_axis_tdata[7:0];
            next_byte_reg <= s_axis_tdata[15:8];
        end
        if (advance)
        begin
            out_byte_reg <= step_byte;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

endmodule
